/* src/gesture_class_vote_filter_unit_macros.svh */
// Assertion macros for the gesture class vote filter checker.
// Depends on nothing; expects clk and rst in the scope where a macro is used.
`ifndef GESTURE_CLASS_VOTE_FILTER_UNIT_MACROS_SVH
`define GESTURE_CLASS_VOTE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GCVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GCVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gcvf_pkg.sv */
// Shared types and constants for the gesture class vote filter.
// No dependencies; used by the top level and the checker.
package gcvf_pkg;

  localparam int HISTORY_LEN_DEF = 8;
  localparam int CLASS_COUNT_DEF = 10;

  localparam int CODE_W  = 5;
  localparam int TIME_W  = 32;
  localparam int HOLD_W  = 16;
  localparam int VOTE_W  = 4;
  localparam int ENTRY_W = 4;
  localparam int DIGIT_W = 4;

  localparam int S_TDATA_W = 40;  // class_code, now_ms, zero fill
  localparam int M_TDATA_W = 8;   // toggle, backspace, digit_valid, digit, zero fill

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES  = 2'd2;

  localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = 16'd500;
  localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = 16'd2000;
  localparam logic [VOTE_W-1:0] MIN_VOTES_RST  = 4'd2;

  localparam logic [CODE_W-1:0]  CTRL_CODE   = 5'd10;
  localparam logic [CODE_W-1:0]  FAIL_CODE   = 5'b11110;
  localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = 4'hF;
  localparam logic [DIGIT_W-1:0] NO_REPORT   = 4'hF;

endpackage

/* src/gcvf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the vote history.
module gcvf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/gesture_class_vote_filter_unit.sv */
// Gesture class vote filter: one verdict beat in, one result beat out. A read failure or a
// control verdict goes from ST_CMP straight to ST_DONE; any other verdict passes through
// ST_DEC, ST_INC, ST_SCAN and ST_VOTE, the scan walking the class counts one per cycle
// through the shared read port of the count file. A new beat is taken only in ST_IDLE,
// once the result of the last one is loaded into the output register. A result still
// waiting in the output register does not stop the next beat being accepted, but that
// beat holds in ST_DONE until the register frees.
// No clearing pass after reset: the history reads as empty until its first wrap, tracked
// by a flag.
// Depends on gcvf_pkg and gcvf_ram.
module gesture_class_vote_filter_unit #(
  parameter int HISTORY_LEN = gcvf_pkg::HISTORY_LEN_DEF,
  parameter int CLASS_COUNT = gcvf_pkg::CLASS_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gcvf_pkg::S_TDATA_W-1:0]  s_tdata,   // [4:0] class_code, [36:5] now_ms
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gcvf_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] toggle, [1] backspace,
                                                     // [2] digit_valid, [6:3] digit
  input  logic                            cfg_we,
  input  logic [gcvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcvf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gcvf_pkg::*;

  localparam int SLOT_W = $clog2(HISTORY_LEN);
  localparam int CNT_W  = $clog2(HISTORY_LEN + 1);
  localparam int CI_W   = $clog2(CLASS_COUNT);
  localparam int CMP_W  = (CNT_W > VOTE_W) ? CNT_W : VOTE_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CMP  = 7'b0000010,
    ST_DEC  = 7'b0000100,
    ST_INC  = 7'b0001000,
    ST_SCAN = 7'b0010000,
    ST_VOTE = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    KIND_FAIL  = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_CLASS = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  state_t state;

  logic [HOLD_W-1:0] short_hold_ms;
  logic [HOLD_W-1:0] long_hold_ms;
  logic [VOTE_W-1:0] min_votes;

  logic [CNT_W-1:0]   counts [CLASS_COUNT];
  logic [SLOT_W-1:0]  slot;
  logic               filled;
  logic [DIGIT_W-1:0] last_rep;
  logic [TIME_W-1:0]  hold_start;
  logic               hold_active;

  kind_t              kind;
  logic [ENTRY_W-1:0] code_idx;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  diff;
  logic [ENTRY_W-1:0] old_q;
  logic [ENTRY_W-1:0] scan_i;
  logic [ENTRY_W-1:0] lead;
  logic [CNT_W-1:0]   lead_cnt;

  logic               res_toggle;
  logic               res_bksp;
  logic               res_dv;
  logic [DIGIT_W-1:0] res_digit;

  logic [CODE_W-1:0]  in_code;
  logic [TIME_W-1:0]  in_now;
  logic               accept;
  kind_t              in_kind;

  logic [ENTRY_W-1:0] cnt_idx;
  logic [CNT_W-1:0]   cnt_rd;
  logic [ENTRY_W-1:0] hist_rd;
  logic [ENTRY_W-1:0] hist_wdata;
  logic [ENTRY_W-1:0] old_entry;
  logic               out_free;

  assign in_code  = s_tdata[CODE_W-1:0];
  assign in_now   = s_tdata[CODE_W +: TIME_W];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Control is tested before the class range so a colliding class never wins.
  always_comb begin
    priority if (in_code == FAIL_CODE) begin
      in_kind = KIND_FAIL;
    end else if (in_code == CTRL_CODE) begin
      in_kind = KIND_CTRL;
    end else if (!in_code[CODE_W-1] && (in_code[ENTRY_W-1:0] < ENTRY_W'(CLASS_COUNT))) begin
      in_kind = KIND_CLASS;
    end else begin
      in_kind = KIND_NONE;
    end
  end

  // One read port on the count file, steered by the sequencer.
  always_comb begin
    unique case (state)
      ST_DEC:  cnt_idx = old_q;
      ST_INC:  cnt_idx = code_idx;
      default: cnt_idx = scan_i;
    endcase
    if (cnt_idx < ENTRY_W'(CLASS_COUNT)) begin
      cnt_rd = counts[cnt_idx[CI_W-1:0]];
    end else begin
      cnt_rd = '0;
    end
  end

  assign old_entry  = filled ? hist_rd : EMPTY_ENTRY;
  assign hist_wdata = (kind == KIND_CLASS) ? code_idx : EMPTY_ENTRY;

  gcvf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_LEN)
  ) u_hist (
    .clk   (clk),
    .we    (state == ST_DEC),
    .waddr (slot),
    .wdata (hist_wdata),
    .re    (accept),
    .raddr (slot),
    .rdata (hist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      short_hold_ms <= SHORT_HOLD_RST;
      long_hold_ms  <= LONG_HOLD_RST;
      min_votes     <= MIN_VOTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_HOLD: short_hold_ms <= cfg_data;
        CFG_LONG_HOLD:  long_hold_ms  <= cfg_data;
        CFG_MIN_VOTES:  min_votes     <= cfg_data[VOTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot        <= '0;
      filled      <= 1'b0;
      last_rep    <= NO_REPORT;
      hold_start  <= '0;
      hold_active <= 1'b0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            kind       <= in_kind;
            code_idx   <= in_code[ENTRY_W-1:0];
            now_q      <= in_now;
            diff       <= hold_active ? (in_now - hold_start) : '0;
            res_toggle <= 1'b0;
            res_bksp   <= 1'b0;
            res_dv     <= 1'b0;
            res_digit  <= '0;
            state      <= ST_CMP;
          end
        end
        ST_CMP: begin
          old_q <= old_entry;
          unique case (kind)
            KIND_FAIL: begin
              state <= ST_DONE;
            end
            KIND_CTRL: begin
              if (diff > {{(TIME_W-HOLD_W){1'b0}}, long_hold_ms}) begin
                res_toggle  <= 1'b1;
                hold_active <= 1'b0;
              end else if (!hold_active) begin
                hold_active <= 1'b1;
                hold_start  <= now_q;
              end
              state <= ST_DONE;
            end
            default: begin
              res_bksp <= (diff > {{(TIME_W-HOLD_W){1'b0}}, short_hold_ms}) &&
                          (diff < {{(TIME_W-HOLD_W){1'b0}}, long_hold_ms});
              hold_active <= 1'b0;
              state       <= ST_DEC;
            end
          endcase
        end
        ST_DEC: begin
          // Drop the vote that leaves the window; a zero count stays zero.
          if ((old_q < ENTRY_W'(CLASS_COUNT)) && (cnt_rd != '0)) begin
            counts[cnt_idx[CI_W-1:0]] <= cnt_rd - CNT_W'(1);
          end
          state <= ST_INC;
        end
        ST_INC: begin
          if (kind == KIND_CLASS) begin
            counts[cnt_idx[CI_W-1:0]] <= cnt_rd + CNT_W'(1);
          end
          if (slot == SLOT_W'(HISTORY_LEN - 1)) begin
            slot   <= '0;
            filled <= 1'b1;
          end else begin
            slot <= slot + SLOT_W'(1);
          end
          scan_i   <= '0;
          lead     <= '0;
          lead_cnt <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // Strict compare keeps the lowest class on a tie.
          if (cnt_rd > lead_cnt) begin
            lead     <= scan_i;
            lead_cnt <= cnt_rd;
          end
          if (scan_i == ENTRY_W'(CLASS_COUNT - 1)) begin
            state <= ST_VOTE;
          end else begin
            scan_i <= scan_i + ENTRY_W'(1);
          end
        end
        ST_VOTE: begin
          if (CMP_W'(lead_cnt) > CMP_W'(min_votes)) begin
            if (lead != last_rep) begin
              last_rep  <= lead;
              res_dv    <= 1'b1;
              res_digit <= lead;
            end
          end else begin
            last_rep <= NO_REPORT;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hold here until the output register is free.
          if (out_free) begin
            m_tdata <= {1'b0, res_digit, res_dv, res_bksp, res_toggle};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/gcvf_checker.sv */
// Port-level checker for the gesture class vote filter, bound to the top level.
// Depends on gcvf_pkg and gesture_class_vote_filter_unit_macros.svh.
`include "gesture_class_vote_filter_unit_macros.svh"

module gcvf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gcvf_pkg::M_TDATA_W-1:0] m_tdata
);

  import gcvf_pkg::*;

  `GCVF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `GCVF_ASSERT_NOW(a_toggle_bksp, m_tvalid, !(m_tdata[0] && m_tdata[1]), "toggle and backspace in one beat")
  `GCVF_ASSERT_NOW(a_digit_zero, m_tvalid && !m_tdata[2], m_tdata[6:3] == '0, "digit set without digit_valid")
  `GCVF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready held after accepting a beat")

endmodule

bind gesture_class_vote_filter_unit gcvf_checker u_gcvf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
